### rtl/core/shs_pkg.sv
// Shared types, constants and SHA-256 helper functions for the stream hasher.
// No dependencies; sha256_stream_hasher, shs_sched and shs_compress import this package.
`default_nettype none
package shs_pkg;

  typedef logic [31:0]      shs_word_t;
  typedef logic [7:0][31:0] shs_hash_t;  // element 0 holds H0 (or a), element 7 holds H7 (or h)

  // Schedule window control from the sequencer
  typedef struct packed {
    logic      load;   // shift in a message word
    logic      step;   // shift in a derived schedule word
    shs_word_t data;
  } shs_sched_ctrl_t;

  // Compression unit control and status
  typedef struct packed {
    logic start;  // begin a 64-round compression
    logic init;   // return the chaining value to the initial hash
  } shs_cmp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic rounding;  // a round runs this cycle
    logic done;      // chaining value updates at this edge
  } shs_cmp_stat_t;

  localparam shs_hash_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam shs_word_t PAD_MARKER = 32'h8000_0000;
  localparam logic [2:0] WORD_BYTES = 3'd4;
  localparam logic [3:0] LEN_HI_SLOT = 4'd14;
  localparam logic [3:0] LEN_LO_SLOT = 4'd15;

  function automatic shs_word_t shs_rotr(input shs_word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic shs_word_t shs_bsig0(input shs_word_t x);
    return shs_rotr(x, 2) ^ shs_rotr(x, 13) ^ shs_rotr(x, 22);
  endfunction

  function automatic shs_word_t shs_bsig1(input shs_word_t x);
    return shs_rotr(x, 6) ^ shs_rotr(x, 11) ^ shs_rotr(x, 25);
  endfunction

  function automatic shs_word_t shs_ssig0(input shs_word_t x);
    return shs_rotr(x, 7) ^ shs_rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic shs_word_t shs_ssig1(input shs_word_t x);
    return shs_rotr(x, 17) ^ shs_rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic shs_word_t shs_round_k(input logic [5:0] idx);
    shs_word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### rtl/core/shs_in_if.sv
// Input channel of the stream hasher: valid/ready plus one message word item.
// Standalone; no package needed.
`default_nettype none
interface shs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic [2:0]  valid_bytes;
  logic        last;

  modport source (output valid, output msg_word, output valid_bytes, output last,
                  input ready);
  modport sink   (input valid, input msg_word, input valid_bytes, input last,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/shs_out_if.sv
// Result channel of the stream hasher: valid/ready plus one digest word item.
// Standalone; no package needed.
`default_nettype none
interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;

  modport source (output valid, output digest_word, output digest_index,
                  output digest_last, input ready);
  modport sink   (input valid, input digest_word, input digest_index,
                  input digest_last, output ready);
endinterface
`default_nettype wire

### rtl/core/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: input sequencer, padding, digest
// output register. Depends on shs_pkg, shs_in_if, shs_out_if, shs_sched, shs_compress.
//
//   channel  dir  payload                                       handshake
//   in_ch    in   msg_word[31:0] valid_bytes[2:0] last          valid/ready
//   out_ch   out  digest_word[31:0] digest_index[2:0] digest_last valid/ready
//
// A word that does not finish a block is accepted without holding in_ch.ready low; the
// sixteenth word of a block starts 64 rounds on the shared round datapath, then the chain
// update, during which in_ch.ready is low.
// A last word adds one padding word per remaining slot and one or two such
// compressions, then eight digest words, each held while out_ch.ready is low.
// Reset (rst_n, synchronous) restores the initial hash; no clearing pass.
`default_nettype none
module sha256_stream_hasher
  import shs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  shs_in_if.sink    in_ch,
  shs_out_if.source out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_PAD, S_HASH, S_OUT} seq_state_t;

  seq_state_t  state_r, state_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic [63:0] byte_total_r, byte_total_nxt;
  logic        marker_pend_r, marker_pend_nxt;
  logic        len_hi_sent_r, len_hi_sent_nxt;
  logic        pad_active_r, pad_active_nxt;
  logic        final_blk_r, final_blk_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  shs_word_t   out_word_r, out_word_nxt;
  logic [2:0]  out_index_r, out_index_nxt;
  logic        out_last_r, out_last_nxt;

  logic            in_acc;
  logic [2:0]      nb_c;
  shs_word_t       last_word;
  shs_word_t       pad_word;
  logic            push;
  shs_word_t       push_word;
  logic            out_load;
  shs_sched_ctrl_t sched_ctrl;
  shs_cmp_ctrl_t   cmp_ctrl;
  shs_cmp_stat_t   cmp_stat;
  shs_word_t       w_t;
  shs_hash_t       chain;

  shs_sched u_sched (
    .clk  (clk),
    .ctrl (sched_ctrl),
    .w_t  (w_t)
  );

  shs_compress u_compress (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (cmp_ctrl),
    .w_t   (w_t),
    .stat  (cmp_stat),
    .chain (chain)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && (state_r == S_IDLE);
  assign nb_c        = (in_ch.valid_bytes > WORD_BYTES) ? WORD_BYTES : in_ch.valid_bytes;

  // keep the valid leading bytes and append the marker byte right after them
  always_comb begin
    case (nb_c[1:0])
      2'd0:    last_word = PAD_MARKER;
      2'd1:    last_word = {in_ch.msg_word[31:24], 24'h80_0000};
      2'd2:    last_word = {in_ch.msg_word[31:16], 16'h8000};
      2'd3:    last_word = {in_ch.msg_word[31:8], 8'h80};
      default: last_word = PAD_MARKER;
    endcase
  end

  // length field is eight times the byte count
  always_comb begin
    if (marker_pend_r) begin
      pad_word = PAD_MARKER;
    end else if (slot_r == LEN_HI_SLOT && !len_hi_sent_r) begin
      pad_word = byte_total_r[60:29];
    end else if (slot_r == LEN_LO_SLOT && len_hi_sent_r) begin
      pad_word = {byte_total_r[28:0], 3'b000};
    end else begin
      pad_word = '0;
    end
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt       = state_r;
    slot_nxt        = slot_r;
    byte_total_nxt  = byte_total_r;
    marker_pend_nxt = marker_pend_r;
    len_hi_sent_nxt = len_hi_sent_r;
    pad_active_nxt  = pad_active_r;
    final_blk_nxt   = final_blk_r;
    out_idx_nxt     = out_idx_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_word_nxt    = out_word_r;
    out_index_nxt   = out_index_r;
    out_last_nxt    = out_last_r;
    push            = 1'b0;
    push_word       = in_ch.msg_word;
    cmp_ctrl        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          push = 1'b1;
          if (in_ch.last) begin
            byte_total_nxt  = byte_total_r + {61'd0, nb_c};
            marker_pend_nxt = (nb_c == WORD_BYTES);
            len_hi_sent_nxt = 1'b0;
            pad_active_nxt  = 1'b1;
            if (nb_c != WORD_BYTES) begin
              push_word = last_word;
            end
            state_nxt = S_PAD;
          end else begin
            byte_total_nxt = byte_total_r + {61'd0, WORD_BYTES};
          end
        end
      end
      S_PAD: begin
        push            = 1'b1;
        push_word       = pad_word;
        marker_pend_nxt = 1'b0;
        if (!marker_pend_r && slot_r == LEN_HI_SLOT && !len_hi_sent_r) begin
          len_hi_sent_nxt = 1'b1;
        end
        if (!marker_pend_r && slot_r == LEN_LO_SLOT && len_hi_sent_r) begin
          final_blk_nxt = 1'b1;
        end
      end
      S_HASH: begin
        if (cmp_stat.done) begin
          if (final_blk_r) begin
            final_blk_nxt  = 1'b0;
            pad_active_nxt = 1'b0;
            byte_total_nxt = '0;
            out_idx_nxt    = '0;
            state_nxt      = S_OUT;
          end else if (pad_active_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = chain[out_idx_r];
          out_index_nxt = out_idx_r;
          out_last_nxt  = (out_idx_r == 3'd7);
          out_idx_nxt   = out_idx_r + 3'd1;
          if (out_idx_r == 3'd7) begin
            cmp_ctrl.init = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a word in the last slot closes the block
    if (push) begin
      slot_nxt = slot_r + 4'd1;
      if (slot_r == LEN_LO_SLOT) begin
        cmp_ctrl.start = 1'b1;
        state_nxt      = S_HASH;
      end
    end
  end

  always_comb begin
    sched_ctrl.load = push;
    sched_ctrl.step = cmp_stat.rounding;
    sched_ctrl.data = push_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      slot_r        <= '0;
      byte_total_r  <= '0;
      marker_pend_r <= 1'b0;
      len_hi_sent_r <= 1'b0;
      pad_active_r  <= 1'b0;
      final_blk_r   <= 1'b0;
      out_idx_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      slot_r        <= slot_nxt;
      byte_total_r  <= byte_total_nxt;
      marker_pend_r <= marker_pend_nxt;
      len_hi_sent_r <= len_hi_sent_nxt;
      pad_active_r  <= pad_active_nxt;
      final_blk_r   <= final_blk_nxt;
      out_idx_r     <= out_idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_word_r  <= out_word_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.digest_word  = out_word_r;
  assign out_ch.digest_index = out_index_r;
  assign out_ch.digest_last  = out_last_r;

`ifndef ASSERT_OFF
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sched_ctrl.load |-> !cmp_stat.busy)
    else $error("schedule loaded while compression runs");
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_index_r == 3'd7)
    else $error("digest_last on wrong index");
  a_msg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_idx_r == 3'd7) |=> state_r == S_IDLE && slot_r == 4'd0
      && byte_total_r == 64'd0)
    else $error("message state not cleared after digest");
  a_digest_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> slot_r == 4'd0 && !cmp_stat.busy)
    else $error("digest read mid-block");
`endif

endmodule
`default_nettype wire

### rtl/core/shs_sched.sv
// Message schedule: a 16-word sliding window that takes message words and then
// derives one new schedule word per round. Depends on shs_pkg.
`default_nettype none
module shs_sched
  import shs_pkg::*;
(
  input  wire logic            clk,
  input  wire shs_sched_ctrl_t ctrl,
  output shs_word_t            w_t
);

  // win_r[i] holds W(t+i) while round t runs
  logic [15:0][31:0] win_r;
  logic [15:0][31:0] win_nxt;
  shs_word_t         w_new;

  assign w_new = shs_ssig1(win_r[14]) + win_r[9] + shs_ssig0(win_r[1]) + win_r[0];

  always_comb begin
    win_nxt = win_r;
    if (ctrl.load) begin
      win_nxt = {ctrl.data, win_r[15:1]};
    end else if (ctrl.step) begin
      win_nxt = {w_new, win_r[15:1]};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign w_t = win_r[0];

endmodule
`default_nettype wire

### rtl/core/shs_compress.sv
// Compression unit: one shared round datapath reused for 64 rounds, then a
// chaining-value update. Holds the chaining value. Depends on shs_pkg.
`default_nettype none
module shs_compress
  import shs_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire shs_cmp_ctrl_t ctrl,
  input  wire shs_word_t     w_t,
  output shs_cmp_stat_t      stat,
  output shs_hash_t          chain
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} cmp_state_t;

  cmp_state_t state_r, state_nxt;
  logic [5:0] round_r, round_nxt;
  shs_hash_t  v_r, v_nxt;
  shs_hash_t  chain_r, chain_nxt;
  shs_word_t  t1, t2, pick, vote;

  always_comb begin
    pick = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    vote = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1   = v_r[7] + shs_bsig1(v_r[4]) + pick + shs_round_k(round_r) + w_t;
    t2   = shs_bsig0(v_r[0]) + vote;
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    v_nxt     = v_r;
    chain_nxt = chain_r;
    case (state_r)
      C_IDLE: begin
        if (ctrl.start) begin
          v_nxt     = chain_r;
          round_nxt = '0;
          state_nxt = C_ROUND;
        end else if (ctrl.init) begin
          chain_nxt = INIT_H;
        end
      end
      C_ROUND: begin
        v_nxt     = {v_r[6:4], v_r[3] + t1, v_r[2:0], t1 + t2};
        round_nxt = round_r + 6'd1;
        if (round_r == 6'd63) begin
          state_nxt = C_FINAL;
        end
      end
      C_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + v_r[i];
        end
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      round_r <= '0;
      chain_r <= INIT_H;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign stat.busy     = (state_r != C_IDLE);
  assign stat.rounding = (state_r == C_ROUND);
  assign stat.done     = (state_r == C_FINAL);
  assign chain         = chain_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |-> state_r == C_IDLE)
    else $error("compression started while busy");
  a_final_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_FINAL) |-> $past(state_r) == C_ROUND && $past(round_r) == 6'd63)
    else $error("chain update not after round 63");
`endif

endmodule
`default_nettype wire
